// ----- hdl/geofc_pkg.sv -----
// Shared constants, types and the cosine table function for the geofence distance check.
`default_nettype none

package geofc_pkg;

  localparam int COS_TABLE_DEPTH = 1024;

  localparam int LAT_W       = 31;
  localparam int LON_W       = 32;
  localparam int RAD_W       = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_REF_LATITUDE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_LONGITUDE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_M      = 2'd2;

  localparam longint unsigned NINETY_DEG     = 64'd900000000;
  localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
  localparam longint unsigned ONE_Q30        = 64'd1073741824;
  localparam longint unsigned M_PER_UNIT_NUM = 64'd1111949;
  localparam longint unsigned M_PER_UNIT_DEN = 64'd6250000;
  localparam longint unsigned MARGIN_M       = 64'd10;

  localparam longint unsigned COS_DIVS [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

  // Widths of the datapath.
  localparam int MEAN_W = 30;
  localparam int AD_W   = 33;
  localparam int DM_W   = 30;
  localparam int NUM_W  = 21;
  localparam int DEN_W  = 23;
  localparam int RD_W   = 31;
  localparam int COS_W  = 17;
  localparam int LIM_W  = RAD_W + 5;

  localparam int               RD_SHIFT = AD_W;
  localparam longint unsigned  RD_FULL  = (M_PER_UNIT_NUM << RD_SHIFT) / M_PER_UNIT_DEN;
  localparam logic [RD_W-1:0]  RD_Q     = RD_FULL[RD_W-1:0];
  localparam logic [NUM_W-1:0] NUM_Q    = M_PER_UNIT_NUM[NUM_W-1:0];
  localparam logic [DEN_W-1:0] DEN_Q    = M_PER_UNIT_DEN[DEN_W-1:0];

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_ld_t;

  function automatic logic [COS_W-1:0] cos_q16(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned m;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      m = ((x2 * t) >> 30) / COS_DIVS[i];
      t = (m >= ONE_Q30) ? 64'd0 : (ONE_Q30 - m);
    end
    return COS_W'((t + 64'd8192) >> 14);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/geofc_fix_if.sv -----
// Valid/ready channel that carries one position fix.
`default_nettype none

interface geofc_fix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [geofc_pkg::LAT_W-1:0]   fix_latitude;
  logic signed [geofc_pkg::LON_W-1:0]   fix_longitude;

  modport source (output valid, output fix_latitude, output fix_longitude, input ready);
  modport sink   (input valid, input fix_latitude, input fix_longitude, output ready);
endinterface

`default_nettype wire

// ----- hdl/geofc_result_if.sv -----
// Valid/ready channel that carries one geofence verdict.
`default_nettype none

interface geofc_result_if;
  logic valid;
  logic ready;
  logic out_of_range;

  modport source (output valid, output out_of_range, input ready);
  modport sink   (input valid, input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- hdl/geofc_deg2m.sv -----
// Three-stage conversion of a coordinate difference in 1e-7 degree to meters in Q4.
`default_nettype none

module geofc_deg2m (
  input  wire logic                          clk,
  input  wire geofc_pkg::stage_ld_t          ld,
  input  wire logic [geofc_pkg::AD_W-1:0]    ad,
  output logic      [geofc_pkg::DM_W-1:0]    dm
);

  localparam int PW = geofc_pkg::AD_W + geofc_pkg::NUM_W;
  localparam int EW = geofc_pkg::AD_W + geofc_pkg::RD_W;

  logic [EW-1:0]                 est_prod;
  logic [PW-1:0]                 exact_prod;
  logic [geofc_pkg::DM_W-1:0]    q0;
  logic [PW-1:0]                 exact;
  logic [geofc_pkg::DM_W-1:0]    q0_d;
  logic [PW-1:0]                 exact_d;
  logic [PW-1:0]                 back;
  logic [PW-1:0]                 rem;

  assign est_prod   = EW'(ad) * EW'(geofc_pkg::RD_Q);
  assign exact_prod = PW'(ad) * PW'(geofc_pkg::NUM_Q);
  assign rem        = exact_d - back;

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      q0    <= est_prod[geofc_pkg::RD_SHIFT +: geofc_pkg::DM_W];
      exact <= exact_prod;
    end
    if (ld.s3) begin
      q0_d    <= q0;
      exact_d <= exact;
      back    <= PW'(q0) * PW'(geofc_pkg::DEN_Q);
    end
    if (ld.s4) begin
      dm <= q0_d + geofc_pkg::DM_W'(rem >= PW'(geofc_pkg::DEN_Q));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/geofence_distance_check.sv -----
// Top level of the geofence distance check: config registers, pipeline and verdict.
//
// Each fix transfer produces exactly one out_of_range verdict through the nine-stage pipeline,
// and a new fix can be taken in every cycle unless a stall on the result channel has
// backed up to stage 1; a stall holds only the stages that are full. The limit is
// (radius_m + 10 m), compared against the squared equirectangular distance in 1/16 m,
// with the longitude term scaled by a cosine table of COS_TABLE_DEPTH + 1 constant entries.
// Configuration writes take effect at once and must come while no fix is in flight.
`default_nettype none

module geofence_distance_check #(
  parameter int COS_TABLE_DEPTH = geofc_pkg::COS_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  geofc_fix_if.sink                                fix,
  geofc_result_if.source                           result,
  input  wire logic                                cfg_write,
  input  wire logic [geofc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [geofc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int              NSTG  = 9;
  localparam int              IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam longint unsigned NDEG  = geofc_pkg::NINETY_DEG;
  localparam longint unsigned XMAX  = NDEG * COS_TABLE_DEPTH + NDEG / 2;
  localparam int              XW    = $clog2(XMAX + 1);
  localparam longint unsigned RI    = (64'd1 << XW) / NDEG;
  localparam int              RW    = $clog2(RI + 1);
  localparam int              LAT_W = geofc_pkg::LAT_W;
  localparam int              LON_W = geofc_pkg::LON_W;
  localparam int              DM_W  = geofc_pkg::DM_W;
  localparam int              COS_W = geofc_pkg::COS_W;
  localparam int              LIM_W = geofc_pkg::LIM_W;
  localparam int              SQ_W  = 2 * DM_W;

  logic signed [LAT_W-1:0]        ref_latitude;
  logic signed [LON_W-1:0]        ref_longitude;
  logic [geofc_pkg::RAD_W-1:0]    radius_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude  <= '0;
      ref_longitude <= '0;
      radius_m      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        geofc_pkg::REG_REF_LATITUDE:  ref_latitude  <= cfg_data[LAT_W-1:0];
        geofc_pkg::REG_REF_LONGITUDE: ref_longitude <= cfg_data[LON_W-1:0];
        geofc_pkg::REG_RADIUS_M:      radius_m      <= cfg_data[geofc_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;

  assign vin       = {v[NSTG-2:0], fix.valid};

  always_comb begin
    rdy[NSTG] = result.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  assign fix.ready           = rdy[0];
  assign result.valid        = v[NSTG-1];

  // Cosine table.
  logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
    localparam longint unsigned XK = (64'(k) * geofc_pkg::HALF_PI_Q30) / COS_TABLE_DEPTH;
    assign cos_rom[k] = geofc_pkg::cos_q16(XK);
  end

  // Stage 1: mean latitude and absolute differences.
  logic signed [LAT_W:0]          lat_sum;
  logic [LAT_W:0]                 lat_sum_abs;
  logic [LAT_W-1:0]               lat_mean;
  logic signed [LAT_W:0]          lat_diff;
  logic signed [LON_W:0]          lon_diff;
  logic [geofc_pkg::MEAN_W-1:0]   s1_mean;
  logic [geofc_pkg::AD_W-1:0]     s1_ad_lat;
  logic [geofc_pkg::AD_W-1:0]     s1_ad_lon;

  assign lat_sum     = {fix.fix_latitude[LAT_W-1], fix.fix_latitude}
                     + {ref_latitude[LAT_W-1], ref_latitude};
  assign lat_sum_abs = lat_sum[LAT_W] ? (LAT_W + 1)'(-lat_sum) : (LAT_W + 1)'(lat_sum);
  assign lat_mean    = lat_sum_abs[LAT_W:1];
  assign lat_diff    = {fix.fix_latitude[LAT_W-1], fix.fix_latitude}
                     - {ref_latitude[LAT_W-1], ref_latitude};
  assign lon_diff    = {fix.fix_longitude[LON_W-1], fix.fix_longitude}
                     - {ref_longitude[LON_W-1], ref_longitude};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_mean   <= (64'(lat_mean) > NDEG) ? NDEG[geofc_pkg::MEAN_W-1:0]
                                         : lat_mean[geofc_pkg::MEAN_W-1:0];
      s1_ad_lat <= lat_diff[LAT_W] ? geofc_pkg::AD_W'(-lat_diff) : geofc_pkg::AD_W'(lat_diff);
      s1_ad_lon <= lon_diff[LON_W] ? geofc_pkg::AD_W'(-lon_diff) : geofc_pkg::AD_W'(lon_diff);
    end
  end

  // Stages 2 to 4 of the meter conversion.
  geofc_pkg::stage_ld_t  dm_ld;
  logic [DM_W-1:0]       s4_dy;
  logic [DM_W-1:0]       s4_dx;

  assign dm_ld = '{s2: rdy[1], s3: rdy[2], s4: rdy[3]};

  geofc_deg2m u_dy (.clk(clk), .ld(dm_ld), .ad(s1_ad_lat), .dm(s4_dy));
  geofc_deg2m u_dx (.clk(clk), .ld(dm_ld), .ad(s1_ad_lon), .dm(s4_dx));

  // Stages 2 to 5: cosine table index, rounded to the nearest entry.
  logic [XW-1:0]       s2_x;
  logic [XW+RW-1:0]    qi_prod;
  logic [IDX_W-1:0]    s3_qi;
  logic [XW-1:0]       s3_x;
  logic [IDX_W-1:0]    s4_qi;
  logic [XW-1:0]       s4_x;
  logic [XW-1:0]       s4_mi;
  logic [XW-1:0]       idx_rem;
  logic [IDX_W-1:0]    s5_idx;
  logic [DM_W-1:0]     s5_dy;
  logic [DM_W-1:0]     s5_dx;

  assign qi_prod = (XW + RW)'(s2_x) * (XW + RW)'(RI);
  assign idx_rem = s4_x - s4_mi;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_x <= XW'(s1_mean) * XW'(COS_TABLE_DEPTH) + XW'(NDEG / 2);
    end
    if (rdy[2]) begin
      s3_qi <= qi_prod[XW +: IDX_W];
      s3_x  <= s2_x;
    end
    if (rdy[3]) begin
      s4_qi <= s3_qi;
      s4_x  <= s3_x;
      s4_mi <= XW'(s3_qi) * XW'(NDEG);
    end
    if (rdy[4]) begin
      s5_idx <= s4_qi + IDX_W'(idx_rem >= XW'(NDEG));
      s5_dy  <= s4_dy;
      s5_dx  <= s4_dx;
    end
  end

  // Stages 6 to 9: cosine, east scaling, squares and compare.
  logic [COS_W-1:0]          s6_cos;
  logic [DM_W-1:0]           s6_dy;
  logic [DM_W-1:0]           s6_dx;
  logic [DM_W+COS_W-1:0]     ex_prod;
  logic [DM_W-1:0]           s7_ex;
  logic [DM_W-1:0]           s7_dy;
  logic [geofc_pkg::RAD_W:0] rad_margin;
  logic [LIM_W-1:0]          s7_lim;
  logic [SQ_W-1:0]           s8_sy;
  logic [SQ_W-1:0]           s8_sx;
  logic [2*LIM_W-1:0]        s8_limsq;
  logic                      s9_out;

  assign ex_prod    = (DM_W + COS_W)'(s6_dx) * (DM_W + COS_W)'(s6_cos);
  assign rad_margin = {1'b0, radius_m} + (geofc_pkg::RAD_W + 1)'(geofc_pkg::MARGIN_M);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_cos <= cos_rom[s5_idx];
      s6_dy  <= s5_dy;
      s6_dx  <= s5_dx;
    end
    if (rdy[6]) begin
      s7_ex  <= ex_prod[16 +: DM_W];
      s7_dy  <= s6_dy;
      s7_lim <= {rad_margin, 4'b0000};
    end
    if (rdy[7]) begin
      s8_sy    <= SQ_W'(s7_dy) * SQ_W'(s7_dy);
      s8_sx    <= SQ_W'(s7_ex) * SQ_W'(s7_ex);
      s8_limsq <= (2 * LIM_W)'(s7_lim) * (2 * LIM_W)'(s7_lim);
    end
    if (rdy[8]) begin
      s9_out <= ((SQ_W + 1)'(s8_sy) + (SQ_W + 1)'(s8_sx)) > (SQ_W + 1)'(s8_limsq);
    end
  end

  assign result.out_of_range = s9_out;

  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> (v == '0))
    else $error("pipeline not empty after reset");

  a_stall_from_result : assert property (@(posedge clk) disable iff (rst)
      !result.valid |-> fix.ready)
    else $error("fix channel stalled while the result stage is empty");

  a_idx_estimate : assert property (@(posedge clk) disable iff (rst)
      v[3] |-> (s4_x >= s4_mi) && (idx_rem < XW'(2 * NDEG)))
    else $error("table index estimate off by more than one");

  a_idx_bound : assert property (@(posedge clk) disable iff (rst)
      v[4] |-> (32'(s5_idx) <= COS_TABLE_DEPTH))
    else $error("cosine table index beyond the table");

endmodule

`default_nettype wire
